// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Command codes and the control structure shared by the modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	// Operation codes carried on cmd.
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_ERASE  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // register the incoming item
		logic update;    // apply the operation to the entry array
	} lkvc_ctrl_t;

endpackage

// File: hdl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// LRU cache datapath
// Holds the entries in registers, compares keys in parallel as an item is
// captured and then updates ranks, valid bits and the result.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkvc_pkg::lkvc_ctrl_t  ctrl,
	input  logic [1:0]            cmd,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [DATA_BITS-1:0]  data_in,
	input  logic                  cfg_valid,
	input  logic [6:0]            cfg_data,
	output logic                  hit,
	output logic [DATA_BITS-1:0]  data_out,
	output logic                  inserted,
	output logic                  evicted,
	output logic [6:0]            occupancy
);
	import lkvc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [KEY_BITS-1:0]  keys_q [ENTRIES];
	logic [DATA_BITS-1:0] vals_q [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;
	logic [IW-1:0]        rank_q [ENTRIES];
	logic [CW-1:0]        count_q;
	logic [6:0]           cap_q;

	logic [1:0]           cmd_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [DATA_BITS-1:0] din_s1;
	logic [ENTRIES-1:0]   match_s1;

	// Capture the item and compare its key against every entry.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_s1 <= cmd;
			key_s1 <= key;
			din_s1 <= data_in;
			for (int i = 0; i < ENTRIES; i++) begin
				match_s1[i] <= valid_q[i] && (keys_q[i] == key);
			end
		end
	end

	// Selection of the hit slot, free slot and least recent slot.
	logic          any_hit, any_free, any_valid;
	logic [IW-1:0] hit_idx, free_idx, lru_idx;
	logic [IW-1:0] hit_rank;
	logic [CW-1:0] live_cap;
	logic [CW-1:0] cnt_m1;

	always_comb begin
		any_hit = 1'b0; hit_idx = '0;
		any_free = 1'b0; free_idx = '0;
		any_valid = 1'b0; lru_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				any_hit = 1'b1; hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				any_free = 1'b1; free_idx = IW'(i);
			end
		end
		// The least recent valid entry holds rank count-1.
		cnt_m1 = count_q - CW'(1);
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (CW'(rank_q[i]) == cnt_m1)) begin
				any_valid = 1'b1; lru_idx = IW'(i);
			end
		end
		hit_rank = rank_q[hit_idx];
		if (cap_q == 7'd0) begin
			live_cap = CW'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			live_cap = CW'(ENTRIES);
		end else begin
			live_cap = CW'(cap_q);
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'd64;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Apply the operation to the entry state and form the result.
	logic          do_touch, do_fill, do_evict, do_erase;
	logic          known_hit;
	logic [IW-1:0] tgt;
	logic [IW-1:0] tgt_rank;

	always_comb begin
		do_touch = 1'b0; do_fill = 1'b0; do_evict = 1'b0; do_erase = 1'b0;
		tgt = hit_idx;
		case (cmd_s1)
			CMD_LOOKUP: do_touch = any_hit;
			CMD_INSERT: begin
				if (any_hit) begin
					do_touch = 1'b1;
				end else if (count_q < live_cap) begin
					do_fill = any_free;
					tgt = free_idx;
				end else begin
					do_evict = any_valid;
					tgt = lru_idx;
				end
			end
			CMD_ERASE: do_erase = any_hit;
			default: ;
		endcase
		tgt_rank = rank_q[tgt];
		// An unused command reports no hit.
		known_hit = any_hit && (cmd_s1 inside {CMD_LOOKUP, CMD_INSERT, CMD_ERASE});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (ctrl.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_touch || do_evict) begin
					if (IW'(i) == tgt) rank_q[i] <= '0;
					else if (valid_q[i] && rank_q[i] < tgt_rank) rank_q[i] <= rank_q[i] + IW'(1);
				end else if (do_fill) begin
					if (IW'(i) == tgt) rank_q[i] <= '0;
					else if (valid_q[i]) rank_q[i] <= rank_q[i] + IW'(1);
				end else if (do_erase) begin
					if (IW'(i) == tgt) rank_q[i] <= '0;
					else if (valid_q[i] && rank_q[i] > hit_rank) rank_q[i] <= rank_q[i] - IW'(1);
				end
			end
			if (do_fill) begin
				valid_q[tgt] <= 1'b1;
				count_q <= count_q + CW'(1);
			end else if (do_erase) begin
				valid_q[tgt] <= 1'b0;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Key and value storage, written on a new entry.
	always_ff @(posedge clk) begin
		if (ctrl.update && (do_fill || do_evict)) begin
			keys_q[tgt] <= key_s1;
			vals_q[tgt] <= din_s1;
		end
	end

	// Result, registered at the update and held until the next one.
	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			hit      <= known_hit;
			data_out <= known_hit ? vals_q[hit_idx] : '0;
			inserted <= do_fill || do_evict;
			evicted  <= do_evict;
			occupancy <= do_fill  ? 7'(count_q + CW'(1)) :
			             do_erase ? 7'(count_q - CW'(1)) : 7'(count_q);
		end
	end

endmodule

// File: hdl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences each item through compare and update and raises the strobe.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output lkvc_pkg::lkvc_ctrl_t ctrl
);
	import lkvc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state: an accepted item moves to update, then to done.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE:   state_d = start ? ST_UPDATE : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q == ST_UPDATE);
	assign done         = (state_q == ST_DONE);
	assign ctrl.capture = start && !busy;
	assign ctrl.update  = (state_q == ST_UPDATE);

endmodule

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   An item (cmd, key, data_in) is taken at a clock edge where start is high
//   and busy is low. cmd selects lookup, insert or erase.
//   The key is compared against all entry registers as the item is taken.
//   The cycle after that applies the rank and valid update, and in the cycle
//   after that the result (hit, data_out, inserted, evicted, occupancy)
//   stands on its ports, marked by done; it cannot be held off.
//   busy is high only in the update cycle. A new item may be given while the
//   previous result is shown, so the next item is taken once the update is through.
//   The capacity register is written through cfg_valid/cfg_ready/cfg_data,
//   always ready; write it only while the block is idle.
//   Reset clears all valid bits, ranks and the count, and sets capacity 64.
//   No clearing pass is needed; the block takes items right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [KEY_BITS-1:0]  key,
	input  logic [DATA_BITS-1:0] data_in,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [6:0]           cfg_data,
	output logic                 done,
	output logic                 hit,
	output logic [DATA_BITS-1:0] data_out,
	output logic                 inserted,
	output logic                 evicted,
	output logic [6:0]           occupancy
);
	import lkvc_pkg::*;

	lkvc_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	// Sequencer.
	lkvc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.busy(busy), .done(done), .ctrl(ctrl)
	);

	// Entry storage and update logic.
	lkvc_datapath #(
		.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.cmd(cmd), .key(key), .data_in(data_in),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.hit(hit), .data_out(data_out), .inserted(inserted),
		.evicted(evicted), .occupancy(occupancy)
	);

endmodule

// File: hdl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// LRU cache port checker
// Checks result timing and flag consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       hit,
	input logic       inserted,
	input logic       evicted,
	input logic [6:0] occupancy
);
	// An accepted item is always answered with done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("missing result");

	// A result only follows an accepted item.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without item");

	// Eviction is a kind of insertion and never comes with a hit.
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> inserted && !hit) else $error("bad evict flags");

	// Occupancy never exceeds the store size.
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy <= 7'd64) else $error("occupancy too large");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.hit(hit), .inserted(inserted), .evicted(evicted), .occupancy(occupancy)
);

// File: tb/lru_key_value_cache_test.sv
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives lookup, insert, erase and unused items into the cache under several
// capacity settings and with random sender gaps. Every result is checked field
// by field against the directed table or a behavioural model of the store.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lkvc_pkg::*;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic [31:0] data;
		logic        ins;
		logic        ev;
		logic [6:0]  occ;
	} cache_result_t;

	typedef struct {
		logic [1:0]    op;
		logic [31:0]   k;
		logic [31:0]   d;
		bit            known;
		cache_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [1:0] cmd;
	logic [31:0] key, data_in, data_out;
	logic [6:0] cfg_data, occupancy;
	logic hit, inserted, evicted;

	// Model of the store.
	logic [31:0] slot_key [SLOTS];
	logic [31:0] slot_val [SLOTS];
	bit          slot_live [SLOTS];
	int          slot_age [SLOTS];
	int          live_count;
	int          cap_reg;

	cache_result_t pending_results [$];
	int fails;
	int cycles;
	int idle_pct;

	lru_key_value_cache dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .key(key), .data_in(data_in),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .hit(hit), .data_out(data_out), .inserted(inserted),
		.evicted(evicted), .occupancy(occupancy)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Capacity in effect: zero acts as one, large values clamp to the store.
	function automatic int usable_capacity();
		if (cap_reg == 0) return 1;
		if (cap_reg > SLOTS) return SLOTS;
		return cap_reg;
	endfunction

	// Move slot s to the front; entries that were ahead of it age by one.
	task automatic make_recent(int s);
		int r;
		r = slot_age[s];
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
		slot_age[s] = 0;
	endtask

	// Apply one item to the model and return the result it should produce.
	task automatic apply_cache_op(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] d, output cache_result_t r);
		int s;
		int slot;
		int oldest;
		int age;
		s = -1;
		slot = -1;
		oldest = 0;
		r = '0;
		for (int i = 0; i < SLOTS; i++)
			if (s < 0 && slot_live[i] && slot_key[i] == k) s = i;
		case (op)
			CMD_LOOKUP: begin
				if (s >= 0) begin
					r.hit = 1'b1;
					r.data = slot_val[s];
					make_recent(s);
				end
			end
			CMD_INSERT: begin
				if (s >= 0) begin
					r.hit = 1'b1;
					r.data = slot_val[s];
					make_recent(s);
				end else if (live_count < usable_capacity()) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && !slot_live[i]) slot = i;
					if (slot >= 0) begin
						for (int i = 0; i < SLOTS; i++)
							if (slot_live[i]) slot_age[i]++;
						slot_live[slot] = 1'b1;
						slot_age[slot] = 0;
						live_count++;
					end
				end else begin
					// Full: replace the least recent entry.
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i] && (slot < 0 || slot_age[i] > oldest)) begin
							slot = i;
							oldest = slot_age[i];
						end
					if (slot >= 0) begin
						r.ev = 1'b1;
						make_recent(slot);
					end
				end
				if (s < 0 && slot >= 0) begin
					slot_key[slot] = k;
					slot_val[slot] = d;
					r.ins = 1'b1;
				end
			end
			CMD_ERASE: begin
				if (s >= 0) begin
					age = slot_age[s];
					r.hit = 1'b1;
					r.data = slot_val[s];
					slot_live[s] = 1'b0;
					slot_age[s] = 0;
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i] && slot_age[i] > age) slot_age[i]--;
					if (live_count > 0) live_count--;
				end
			end
			default: ;
		endcase
		r.occ = live_count[6:0];
	endtask

	// Offer one item after a random gap and record its expected result.
	task automatic send_item(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] d, input bit known, input cache_result_t typed);
		int gap;
		cache_result_t r;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		key <= k;
		data_in <= d;
		do @(posedge clk); while (busy);
		apply_cache_op(op, k, d, r);
		pending_results.push_back(known ? typed : r);
	endtask

	// Wait for the block to drain, then write the capacity register.
	task automatic write_capacity(input logic [6:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = v;
	endtask

	// Random traffic; most keys come from two pools, each a little larger than the capacity.
	task automatic random_phase(input int count);
		int sel;
		logic [1:0] op;
		logic [31:0] k;
		int pool;
		for (int n = 0; n < count; n++) begin
			pool = usable_capacity() + usable_capacity() / 2 + 2;
			sel = $urandom_range(0, 99);
			if (sel < 45) op = CMD_INSERT;
			else if (sel < 80) op = CMD_LOOKUP;
			else if (sel < 97) op = CMD_ERASE;
			else op = CMD_UNUSED;
			if ($urandom_range(0, 99) < 12) k = $urandom;
			else k = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0) | $urandom_range(0, pool);
			send_item(op, k, $urandom, 1'b0, '0);
		end
	endtask

	// Results arrive for one cycle only; compare against the oldest expectation.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				fails++;
			end else begin
				automatic cache_result_t e = pending_results.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit); fails++;
				end
				if (data_out !== e.data) begin
					$error("data_out: expected %h, got %h", e.data, data_out); fails++;
				end
				if (inserted !== e.ins) begin
					$error("inserted: expected %0d, got %0d", e.ins, inserted); fails++;
				end
				if (evicted !== e.ev) begin
					$error("evicted: expected %0d, got %0d", e.ev, evicted); fails++;
				end
				if (occupancy !== e.occ) begin
					$error("occupancy: expected %0d, got %0d", e.occ, occupancy); fails++;
				end
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		int caps [8];
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOOKUP;
		key = '0;
		data_in = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fails = 0;
		cycles = 0;
		idle_pct = 28;
		cap_reg = 64;
		live_count = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end

		// Directed items: extremes of key and data, every command, erase miss.
		rows = '{
			'{CMD_LOOKUP, 32'h0, 32'h1234_5678, 1, '{0, 32'h0, 0, 0, 7'd0}},
			'{CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1, '{0, 32'h0, 1, 0, 7'd1}},
			'{CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1, '{0, 32'h0, 1, 0, 7'd2}},
			'{CMD_INSERT, 32'h7fff_ffff, 32'h0, 1, '{1, 32'h8000_0000, 0, 0, 7'd2}},
			'{CMD_LOOKUP, 32'h8000_0000, 32'h0, 1, '{1, 32'h7fff_ffff, 0, 0, 7'd2}},
			'{CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1, '{0, 32'h0, 0, 0, 7'd2}},
			'{CMD_ERASE, 32'h0, 32'h0, 1, '{0, 32'h0, 0, 0, 7'd2}},
			'{CMD_ERASE, 32'h7fff_ffff, 32'h0, 1, '{1, 32'h8000_0000, 0, 0, 7'd1}},
			'{CMD_LOOKUP, 32'h7fff_ffff, 32'h0, 1, '{0, 32'h0, 0, 0, 7'd1}},
			'{CMD_INSERT, 32'h0, 32'hffff_ffff, 1, '{0, 32'h0, 1, 0, 7'd2}},
			'{CMD_INSERT, 32'hffff_ffff, 32'h0, 1, '{0, 32'h0, 1, 0, 7'd3}},
			'{CMD_LOOKUP, 32'hffff_ffff, 32'h0, 0, '0},
			'{CMD_LOOKUP, 32'h0, 32'h0, 0, '0},
			'{CMD_ERASE, 32'h8000_0000, 32'h0, 0, '0},
			'{CMD_INSERT, 32'h5555_aaaa, 32'haaaa_5555, 0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].op, rows[i].k, rows[i].d, rows[i].known, rows[i].res);

		// Capacity sweep: one, zero, small, full store, clamp, lowered, small, full store.
		caps = '{1, 0, 2, 64, 127, 3, 5, 64};
		foreach (caps[p]) begin
			write_capacity(caps[p][6:0]);
			case (p % 3)
				0: idle_pct = 28;
				1: idle_pct = 49;
				default: idle_pct = 0;
			endcase
			random_phase((caps[p] >= 64) ? 300 : 200);
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fails == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

// File: files.f
hdl/lkvc_pkg.sv
hdl/lkvc_datapath.sv
hdl/lkvc_ctrl.sv
hdl/lru_key_value_cache.sv
hdl/lkvc_checker.sv
tb/lru_key_value_cache_test.sv
